FILE: rtl/ird_pkg.sv
package ird_pkg;

   localparam int SENSOR_COUNT = 8;
   localparam int CORDIC_STEPS = 16;
   localparam int INPUT_FIELDS = 8;
   localparam int MAX_STEPS = 24;

   localparam int SENSOR_USED = (SENSOR_COUNT < INPUT_FIELDS) ? SENSOR_COUNT : INPUT_FIELDS;
   localparam int STEPS_USED = (CORDIC_STEPS < MAX_STEPS) ? CORDIC_STEPS : MAX_STEPS;

   localparam int STR_W = 10;
   localparam int COS_W = 16;
   localparam int PROD_W = STR_W + 1 + COS_W;
   localparam int SUM_W = PROD_W + 3;
   localparam int XY_W = SUM_W + 2;
   localparam int ANG_W = 24;
   localparam int STEP_W = $clog2(MAX_STEPS);
   localparam int BEARING_W = 13;
   localparam int Q_W = ANG_W - 8;

   localparam logic [STR_W-1:0] THRESHOLD_RESET = 10'd300;
   localparam logic [STR_W-1:0] STRENGTH_MAX = 10'd1023;
   localparam logic signed [ANG_W-1:0] HALF_TURN_Q12 = 24'sd737280;
   localparam logic signed [ANG_W-1:0] ROUND_HALF = 24'sd128;
   localparam logic signed [Q_W-1:0] FULL_TURN = 16'sd5760;
   localparam logic [BEARING_W-1:0] EMPTY_BEARING = 13'd4320;

   typedef logic signed [COS_W-1:0] cos_type;

   typedef struct packed {
      logic                    valid;
      logic                    special;
      logic                    nothing_seen;
      logic signed [XY_W-1:0]  x;
      logic signed [XY_W-1:0]  y;
      logic signed [ANG_W-1:0] ang;
   } cord_data_type;

   // Q1.14 cosine, sixteen points at 22.5 degree spacing
   function automatic cos_type cos_q14(input logic [3:0] pos);
      cos_type c;
      case (pos)
         4'd0:  c = 16'sd16384;
         4'd1:  c = 16'sd15137;
         4'd2:  c = 16'sd11585;
         4'd3:  c = 16'sd6270;
         4'd4:  c = 16'sd0;
         4'd5:  c = -16'sd6270;
         4'd6:  c = -16'sd11585;
         4'd7:  c = -16'sd15137;
         4'd8:  c = -16'sd16384;
         4'd9:  c = -16'sd15137;
         4'd10: c = -16'sd11585;
         4'd11: c = -16'sd6270;
         4'd12: c = 16'sd0;
         4'd13: c = 16'sd6270;
         4'd14: c = 16'sd11585;
         4'd15: c = 16'sd15137;
         default: c = 16'sd0;
      endcase
      return c;
   endfunction

   // nearest 22.5 degree slot for sensor i
   function automatic logic [3:0] sensor_pos(input int i);
      int p;
      p = (i * 16 + SENSOR_COUNT / 2) / SENSOR_COUNT;
      return p[3:0];
   endfunction

   // atan(2^-i) in 1/4096 degree
   function automatic logic signed [ANG_W-1:0] atan_q12(input logic [STEP_W-1:0] i);
      logic signed [ANG_W-1:0] a;
      case (i)
         5'd0:  a = 24'sd184320;
         5'd1:  a = 24'sd108810;
         5'd2:  a = 24'sd57492;
         5'd3:  a = 24'sd29184;
         5'd4:  a = 24'sd14649;
         5'd5:  a = 24'sd7331;
         5'd6:  a = 24'sd3667;
         5'd7:  a = 24'sd1833;
         5'd8:  a = 24'sd917;
         5'd9:  a = 24'sd458;
         5'd10: a = 24'sd229;
         5'd11: a = 24'sd115;
         5'd12: a = 24'sd57;
         5'd13: a = 24'sd29;
         5'd14: a = 24'sd14;
         5'd15: a = 24'sd7;
         5'd16: a = 24'sd4;
         5'd17: a = 24'sd2;
         5'd18: a = 24'sd1;
         default: a = 24'sd0;
      endcase
      return a;
   endfunction

endpackage

FILE: rtl/ird_sum.sv
module ird_sum
   import ird_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  logic [STR_W-1:0]        raw [INPUT_FIELDS],
   input  logic [STR_W-1:0]        threshold,
   output cord_data_type           dout
);

   // stage 1: per-sensor products
   logic                     s1_valid_ff;
   logic                     s1_seen_ff;
   logic signed [PROD_W-1:0] px_ff [SENSOR_USED];
   logic signed [PROD_W-1:0] py_ff [SENSOR_USED];
   logic                     s1_seen_in;
   logic signed [PROD_W-1:0] px_in [SENSOR_USED];
   logic signed [PROD_W-1:0] py_in [SENSOR_USED];

   always_comb begin
      logic [STR_W-1:0]    strength;
      logic signed [STR_W:0] sw;
      logic [3:0]          pos;
      s1_seen_in = 1'b0;
      for (int i = 0; i < SENSOR_USED; i++) begin
         strength = STRENGTH_MAX - raw[i];
         sw = $signed({1'b0, strength});
         pos = sensor_pos(i);
         if (strength >= threshold) begin
            s1_seen_in = 1'b1;
            px_in[i] = sw * cos_q14(pos);
            py_in[i] = sw * cos_q14(pos + 4'd12);
         end else begin
            px_in[i] = '0;
            py_in[i] = '0;
         end
      end
   end

   // stage 2: vector sum
   logic                    s2_valid_ff;
   logic                    s2_seen_ff;
   logic signed [SUM_W-1:0] sx_ff, sy_ff;
   logic signed [SUM_W-1:0] sx_in, sy_in;

   always_comb begin
      sx_in = '0;
      sy_in = '0;
      for (int i = 0; i < SENSOR_USED; i++) begin
         sx_in = sx_in + SUM_W'(px_ff[i]);
         sy_in = sy_in + SUM_W'(py_ff[i]);
      end
   end

   // stage 3: fold into the right half plane, flag the null vector
   cord_data_type d3_ff, d3_in;

   always_comb begin
      logic signed [XY_W-1:0] wx, wy;
      wx = XY_W'(sx_ff);
      wy = XY_W'(sy_ff);
      d3_in.valid = s2_valid_ff;
      d3_in.special = (sx_ff == '0) && (sy_ff == '0);
      d3_in.nothing_seen = !s2_seen_ff;
      if (sx_ff < 0) begin
         d3_in.x = -wx;
         d3_in.y = -wy;
         d3_in.ang = HALF_TURN_Q12;
      end else begin
         d3_in.x = wx;
         d3_in.y = wy;
         d3_in.ang = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         d3_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s1_seen_ff <= s1_seen_in;
         px_ff <= px_in;
         py_ff <= py_in;
         s2_valid_ff <= s1_valid_ff;
         s2_seen_ff <= s1_seen_ff;
         sx_ff <= sx_in;
         sy_ff <= sy_in;
         d3_ff <= d3_in;
      end
   end

   assign dout = d3_ff;

endmodule

FILE: rtl/ird_cordic_cell.sv
module ird_cordic_cell
   import ird_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [STEP_W-1:0] step_idx,
   input  cord_data_type     din,
   output cord_data_type     dout
);

   cord_data_type data_ff, data_in;

   always_comb begin
      logic signed [XY_W-1:0] dx, dy;
      dx = din.y >>> step_idx;
      dy = din.x >>> step_idx;
      data_in = din;
      if (din.y >= 0) begin
         data_in.x = din.x + dx;
         data_in.y = din.y - dy;
         data_in.ang = din.ang + atan_q12(step_idx);
      end else begin
         data_in.x = din.x - dx;
         data_in.y = din.y + dy;
         data_in.ang = din.ang - atan_q12(step_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff.valid <= 1'b0;
      end else if (advance) begin
         data_ff <= data_in;
      end
   end

   assign dout = data_ff;

endmodule

FILE: rtl/ir_ring_direction_estimator_top.sv
// Bearing estimator for a ring of eight IR sensors. Each item is one scan of
// raw readings; strengths (1023 - raw) at or above the threshold register are
// summed as vectors and a pipelined CORDIC, one cell per iteration, turns the
// sum into a bearing in 1/16 degree. A new item is accepted every cycle unless
// the pipeline holds. The pipeline runs through three front-end stages
// (products, sum, half-plane fold), the cell chain, and the output
// register. The whole pipeline holds while the output register carries an
// item that the receiver stalls. No counting sensor gives 270 degrees with
// nothing_seen set; a threshold write takes effect for the next item.
module ir_ring_direction_estimator_top
   import ird_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [STR_W-1:0]     csr_wr_data,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [STR_W-1:0]     req_raw_0,
   input  logic [STR_W-1:0]     req_raw_1,
   input  logic [STR_W-1:0]     req_raw_2,
   input  logic [STR_W-1:0]     req_raw_3,
   input  logic [STR_W-1:0]     req_raw_4,
   input  logic [STR_W-1:0]     req_raw_5,
   input  logic [STR_W-1:0]     req_raw_6,
   input  logic [STR_W-1:0]     req_raw_7,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [BEARING_W-1:0] rsp_bearing,
   output logic                 rsp_nothing_seen
);

   logic [STR_W-1:0] threshold_ff;
   logic             advance;
   logic [STR_W-1:0] raw [INPUT_FIELDS];
   cord_data_type    chain [STEPS_USED+1];

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BEARING_W-1:0] rsp_bearing_ff, rsp_bearing_in;
   logic                 rsp_nothing_seen_ff, rsp_nothing_seen_in;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   assign raw[0] = req_raw_0;
   assign raw[1] = req_raw_1;
   assign raw[2] = req_raw_2;
   assign raw[3] = req_raw_3;
   assign raw[4] = req_raw_4;
   assign raw[5] = req_raw_5;
   assign raw[6] = req_raw_6;
   assign raw[7] = req_raw_7;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else if (csr_wr_en) begin
         threshold_ff <= csr_wr_data;
      end
   end

   ird_sum u_sum (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .raw       (raw),
      .threshold (threshold_ff),
      .dout      (chain[0])
   );

   for (genvar g = 0; g < STEPS_USED; g++) begin : g_cell
      ird_cordic_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .step_idx (STEP_W'(g)),
         .din      (chain[g]),
         .dout     (chain[g+1])
      );
   end

   // round to 1/16 degree, halves upward, then wrap into one turn
   always_comb begin
      cord_data_type           last;
      logic signed [ANG_W-1:0] t;
      logic signed [Q_W-1:0]   q;
      last = chain[STEPS_USED];
      t = last.ang + ROUND_HALF;
      q = Q_W'(t >>> 8);
      if (q < 0) begin
         q = q + FULL_TURN;
      end else if (q >= FULL_TURN) begin
         q = q - FULL_TURN;
      end
      rsp_valid_in = last.valid;
      if (last.special) begin
         rsp_bearing_in = EMPTY_BEARING;
         rsp_nothing_seen_in = last.nothing_seen;
      end else begin
         rsp_bearing_in = q[BEARING_W-1:0];
         rsp_nothing_seen_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
         rsp_bearing_ff <= rsp_bearing_in;
         rsp_nothing_seen_ff <= rsp_nothing_seen_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_bearing = rsp_bearing_ff;
   assign rsp_nothing_seen = rsp_nothing_seen_ff;

endmodule
